// File: sv/rgr_pkg.sv
// Shared types and constants of the rank group resequencer.
`default_nettype none
package rgr_pkg;

    localparam int RecordSlotsDefault   = 64;
    localparam int GroupSlotsDefault    = 16;
    localparam int CheckIntervalDefault = 10;
    localparam int MaxResults           = 64;

    localparam logic [7:0]  STEP_RESET  = 8'd2;
    localparam logic [19:0] LIMIT_RESET = 20'd500000;
    localparam logic [19:0] MT_SAT      = 20'hFFFFF;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_PAIR     = 3'd1;
    localparam logic [2:0] ERR_MISSING  = 3'd2;
    localparam logic [2:0] ERR_MISORDER = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    localparam logic REG_STEP  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [31:0] rank_value;
        logic        first_read;
        logic        second_read;
        logic [15:0] record_handle;
        logic        end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [15:0] out_handle;
        logic [31:0] out_rank;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out_word;

endpackage
`default_nettype wire

// File: sv/rank_group_resequencer_top.sv
// A word passes the store and finishing states; one that closes an in-order group first passes
// the close state and reads and emits each of its handles, and any output stall holds it.
// A search check scans the group table once for the minimum and then up to twice per group,
// once to check that the ranks run in order and, when they do, once more to emit them.
// Throughput: one word at a time; the next word is taken once all results are queued.
// Reset: synchronous active-low; state and most counters clear, step and limit take their
// reset values, and the record and group stores and data registers are left undefined.
`default_nettype none
module rank_group_resequencer_top #(
    parameter int RECORD_SLOTS   = rgr_pkg::RecordSlotsDefault,
    parameter int GROUP_SLOTS    = rgr_pkg::GroupSlotsDefault,
    parameter int CHECK_INTERVAL = rgr_pkg::CheckIntervalDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  rgr_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rgr_pkg::t_out_word  o_out_word,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int FW  = $clog2(RECORD_SLOTS + 1);
    localparam int AW  = $clog2(RECORD_SLOTS);
    localparam int GW  = $clog2(GROUP_SLOTS + 1);
    localparam int GAW = $clog2(GROUP_SLOTS);
    localparam int RW  = $clog2(rgr_pkg::MaxResults + 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_STORE    = 12'b000000000010,
        S_CLOSE    = 12'b000000000100,
        S_TAIL     = 12'b000000001000,
        S_MIN_RD   = 12'b000000010000,
        S_MIN_CMP  = 12'b000000100000,
        S_SCAN_RD  = 12'b000001000000,
        S_SCAN_CMP = 12'b000010000000,
        S_SPAN_RD  = 12'b000100000000,
        S_SPAN_PUT = 12'b001000000000,
        S_ERR      = 12'b010000000000,
        S_FIN      = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [7:0]  r_step, n_step;
    logic [19:0] r_limit, n_limit;
    logic [31:0] r_exp, n_exp;
    logic        r_search, n_search;
    logic [31:0] r_open_rank, n_open_rank;
    logic [2:0]  r_marks, n_marks;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_olen, n_olen;
    logic [GW-1:0] r_gc, n_gc;
    logic [3:0]  r_ic, n_ic;
    logic [19:0] r_mt, n_mt;
    logic        r_seen, n_seen;
    logic [2:0]  r_halt, n_halt;
    rgr_pkg::t_in_word r_in, n_in;
    logic        r_cl_eos, n_cl_eos;
    logic [2:0]  r_err_code, n_err_code;
    logic [31:0] r_err_rank, n_err_rank;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [FW-1:0] r_cnt, n_cnt;
    logic [31:0] r_span_rank, n_span_rank;
    logic [GAW-1:0] r_idx, n_idx;
    logic [GW-1:0] r_match, n_match;
    logic [31:0] r_want, n_want;
    logic [31:0] r_min, n_min;
    logic [1:0]  r_hits, n_hits;
    logic        r_gap, n_gap;
    logic [AW-1:0] r_hs, n_hs;
    logic [FW-1:0] r_hl, n_hl;
    logic        r_flush, n_flush;
    logic [RW-1:0] r_nres, n_nres;
    logic        r_hold_v, n_hold_v;
    rgr_pkg::t_out_word r_hold, n_hold;
    logic        r_out_v, n_out_v;
    rgr_pkg::t_out_word r_out, n_out;

    logic [15:0]   hmem [RECORD_SLOTS];
    logic [31:0]   tab_rank [GROUP_SLOTS];
    logic [AW-1:0] tab_start [GROUP_SLOTS];
    logic [FW-1:0] tab_len [GROUP_SLOTS];
    logic [15:0]   r_hd;
    logic [31:0]   r_tr;
    logic [AW-1:0] r_ts;
    logic [FW-1:0] r_tl;

    logic          h_we;
    logic          t_we;
    logic [GAW-1:0] t_waddr;
    logic [31:0]   t_wrank;
    logic [AW-1:0] t_wstart;
    logic [FW-1:0] t_wlen;

    logic          put_req;
    rgr_pkg::t_out_word put_word;
    logic          out_free;
    logic          can_put;
    logic          put_ok;
    logic          in_acc;
    logic          cfg_wr;
    logic [31:0]   want_prev;

    assign out_free  = !r_out_v || i_out_ready;
    assign can_put   = !r_hold_v || out_free;
    assign put_ok    = (r_nres != RW'(rgr_pkg::MaxResults));
    assign in_acc    = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign want_prev = r_want - {24'd0, r_step};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            rgr_pkg::REG_STEP: prdata = {24'd0, r_step};
            rgr_pkg::REG_LIMIT: prdata = {12'd0, r_limit};
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        logic [FW-1:0] start;
        logic [3:0]    ic_new;
        logic          seen_new;
        logic [31:0]   min_new;
        logic [1:0]    hits_new;
        logic          gap_new;
        logic [AW-1:0] hs_new;
        logic [FW-1:0] hl_new;
        logic          last_idx;

        n_state = r_state;
        n_step = r_step;
        n_limit = r_limit;
        n_exp = r_exp;
        n_search = r_search;
        n_open_rank = r_open_rank;
        n_marks = r_marks;
        n_fill = r_fill;
        n_olen = r_olen;
        n_gc = r_gc;
        n_ic = r_ic;
        n_mt = r_mt;
        n_seen = r_seen;
        n_halt = r_halt;
        n_in = r_in;
        n_cl_eos = r_cl_eos;
        n_err_code = r_err_code;
        n_err_rank = r_err_rank;
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        n_span_rank = r_span_rank;
        n_idx = r_idx;
        n_match = r_match;
        n_want = r_want;
        n_min = r_min;
        n_hits = r_hits;
        n_gap = r_gap;
        n_hs = r_hs;
        n_hl = r_hl;
        n_flush = r_flush;
        n_nres = r_nres;
        h_we = 1'b0;
        t_we = 1'b0;
        t_waddr = r_gc[GAW-1:0];
        t_wrank = r_open_rank;
        start = r_fill - r_olen;
        t_wstart = start[AW-1:0];
        t_wlen = r_olen;
        put_req = 1'b0;
        put_word = '0;
        ic_new = r_ic;
        seen_new = r_seen;
        min_new = r_min;
        hits_new = r_hits;
        gap_new = r_gap;
        hs_new = r_hs;
        hl_new = r_hl;
        last_idx = ((GW'(r_idx) + GW'(1)) == r_gc);

        if (cfg_wr) begin
            case (paddr[2])
                rgr_pkg::REG_STEP: n_step = pwdata[7:0];
                rgr_pkg::REG_LIMIT: n_limit = pwdata[19:0];
                default: n_step = r_step;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && r_halt == rgr_pkg::ERR_NONE) begin
                    n_in = i_in_word;
                    n_cl_eos = 1'b0;
                    n_nres = '0;
                    if (r_marks[2] && i_in_word.rank_value != r_open_rank) begin
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_STORE;
                    end
                end
            end
            S_STORE: begin
                if (r_fill == FW'(RECORD_SLOTS)) begin
                    n_err_code = rgr_pkg::ERR_OVERFLOW;
                    n_err_rank = r_in.rank_value;
                    n_state = S_ERR;
                end else begin
                    h_we = 1'b1;
                    if (!r_marks[2]) begin
                        n_open_rank = r_in.rank_value;
                        n_marks = {1'b1, r_in.second_read, r_in.first_read};
                        n_olen = FW'(1);
                    end else begin
                        n_marks = r_marks | {1'b0, r_in.second_read, r_in.first_read};
                        n_olen = r_olen + FW'(1);
                    end
                    n_fill = r_fill + FW'(1);
                    if (r_in.end_of_stream) begin
                        n_cl_eos = 1'b1;
                        n_state = S_CLOSE;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CLOSE: begin
                n_marks = 3'd0;
                n_olen = '0;
                if (r_marks[1:0] != 2'b11) begin
                    n_err_code = rgr_pkg::ERR_PAIR;
                    n_err_rank = r_open_rank;
                    n_state = S_ERR;
                end else if (!r_search) begin
                    if (r_open_rank == r_exp) begin
                        n_ptr = start[AW-1:0];
                        n_cnt = r_olen;
                        n_span_rank = r_open_rank;
                        n_fill = start;
                        n_exp = r_exp + {24'd0, r_step};
                        n_flush = 1'b0;
                        n_state = S_SPAN_RD;
                    end else begin
                        n_search = 1'b1;
                        t_we = 1'b1;
                        t_waddr = '0;
                        n_gc = GW'(1);
                        n_ic = 4'd0;
                        n_mt = 20'd0;
                        n_seen = 1'b0;
                        if (r_cl_eos) begin
                            n_err_code = rgr_pkg::ERR_MISSING;
                            n_err_rank = r_exp;
                            n_state = S_ERR;
                        end else begin
                            n_state = S_STORE;
                        end
                    end
                end else if (r_gc == GW'(GROUP_SLOTS)) begin
                    n_err_code = rgr_pkg::ERR_OVERFLOW;
                    n_err_rank = r_open_rank;
                    n_state = S_ERR;
                end else begin
                    t_we = 1'b1;
                    n_gc = r_gc + GW'(1);
                    if (r_ic != 4'd15) begin
                        ic_new = r_ic + 4'd1;
                    end
                    n_ic = ic_new;
                    if (r_mt != rgr_pkg::MT_SAT) begin
                        n_mt = r_mt + 20'd1;
                    end
                    seen_new = r_seen || (r_open_rank == r_exp);
                    n_seen = seen_new;
                    n_idx = '0;
                    if ((ic_new >= 4'(CHECK_INTERVAL) || r_cl_eos) && seen_new) begin
                        n_state = S_MIN_RD;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                if (r_cl_eos) begin
                    n_err_code = rgr_pkg::ERR_MISSING;
                    n_err_rank = r_exp;
                    n_state = S_ERR;
                end else if (r_mt >= r_limit) begin
                    n_err_code = rgr_pkg::ERR_MISORDER;
                    n_err_rank = r_exp;
                    n_state = S_ERR;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_MIN_RD: begin
                n_state = S_MIN_CMP;
            end
            S_MIN_CMP: begin
                if (r_idx == '0 || r_tr < r_min) begin
                    min_new = r_tr;
                end
                n_min = min_new;
                if (last_idx) begin
                    n_want = min_new;
                    n_match = '0;
                    n_hits = 2'd0;
                    n_gap = 1'b0;
                    n_flush = 1'b0;
                    n_idx = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    n_idx = r_idx + GAW'(1);
                    n_state = S_MIN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_tr == r_want) begin
                    hits_new = (r_hits == 2'd0) ? 2'd1 : 2'd2;
                    hs_new = r_ts;
                    hl_new = r_tl;
                end
                gap_new = r_gap || (r_tr > want_prev && r_tr < r_want);
                n_hits = hits_new;
                n_gap = gap_new;
                n_hs = hs_new;
                n_hl = hl_new;
                if (!last_idx) begin
                    n_idx = r_idx + GAW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_idx = '0;
                    n_hits = 2'd0;
                    n_gap = 1'b0;
                    if (r_flush) begin
                        n_ptr = hs_new;
                        n_cnt = hl_new;
                        n_span_rank = r_want;
                        n_want = r_want + {24'd0, r_step};
                        n_match = r_match + GW'(1);
                        n_state = S_SPAN_RD;
                    end else if (!gap_new && hits_new == 2'd1) begin
                        if (r_match + GW'(1) == r_gc) begin
                            n_flush = 1'b1;
                            n_want = r_min;
                            n_match = '0;
                        end else begin
                            n_want = r_want + {24'd0, r_step};
                            n_match = r_match + GW'(1);
                        end
                        n_state = S_SCAN_RD;
                    end else begin
                        if (gap_new || hits_new == 2'd0) begin
                            n_exp = r_want;
                        end else begin
                            n_exp = r_want + {24'd0, r_step};
                        end
                        n_ic = 4'd0;
                        n_seen = 1'b0;
                        n_state = S_TAIL;
                    end
                end
            end
            S_SPAN_RD: begin
                if (r_cnt != '0) begin
                    n_state = S_SPAN_PUT;
                end else if (r_flush && r_match != r_gc) begin
                    n_state = S_SCAN_RD;
                end else begin
                    if (r_flush) begin
                        n_exp = r_want;
                        n_gc = '0;
                        n_fill = '0;
                        n_search = 1'b0;
                        n_flush = 1'b0;
                    end
                    n_state = r_cl_eos ? S_FIN : S_STORE;
                end
            end
            S_SPAN_PUT: begin
                if (can_put || !put_ok) begin
                    put_req = put_ok;
                    put_word = '{out_handle: r_hd, out_rank: r_span_rank,
                                 error_code: rgr_pkg::ERR_NONE, last_of_run: 1'b0};
                    n_ptr = r_ptr + AW'(1);
                    n_cnt = r_cnt - FW'(1);
                    n_state = S_SPAN_RD;
                end
            end
            S_ERR: begin
                if (can_put || !put_ok) begin
                    put_req = put_ok;
                    put_word = '{out_handle: 16'd0, out_rank: r_err_rank,
                                 error_code: r_err_code, last_of_run: 1'b0};
                    n_halt = r_err_code;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (put_req) begin
            n_nres = r_nres + RW'(1);
        end

        n_hold = r_hold;
        n_hold_v = r_hold_v;
        n_out = r_out;
        n_out_v = r_out_v && !i_out_ready;
        if (put_req) begin
            if (r_hold_v) begin
                n_out = r_hold;
                n_out_v = 1'b1;
            end
            n_hold = put_word;
            n_hold_v = 1'b1;
        end else if (r_state == S_FIN && r_hold_v && out_free) begin
            n_out = r_hold;
            n_out.last_of_run = 1'b1;
            n_out_v = 1'b1;
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hmem[r_fill[AW-1:0]] <= r_in.record_handle;
        end
        r_hd <= hmem[r_ptr];
        if (t_we) begin
            tab_rank[t_waddr] <= t_wrank;
            tab_start[t_waddr] <= t_wstart;
            tab_len[t_waddr] <= t_wlen;
        end
        r_tr <= tab_rank[r_idx];
        r_ts <= tab_start[r_idx];
        r_tl <= tab_len[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= rgr_pkg::STEP_RESET;
            r_limit <= rgr_pkg::LIMIT_RESET;
            r_exp <= '0;
            r_search <= 1'b0;
            r_open_rank <= '0;
            r_marks <= '0;
            r_fill <= '0;
            r_olen <= '0;
            r_gc <= '0;
            r_ic <= '0;
            r_mt <= '0;
            r_seen <= 1'b0;
            r_halt <= rgr_pkg::ERR_NONE;
            r_cl_eos <= 1'b0;
            r_flush <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v <= 1'b0;
            r_match <= '0;
            r_idx <= '0;
            r_hits <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            r_limit <= n_limit;
            r_exp <= n_exp;
            r_search <= n_search;
            r_open_rank <= n_open_rank;
            r_marks <= n_marks;
            r_fill <= n_fill;
            r_olen <= n_olen;
            r_gc <= n_gc;
            r_ic <= n_ic;
            r_mt <= n_mt;
            r_seen <= n_seen;
            r_halt <= n_halt;
            r_cl_eos <= n_cl_eos;
            r_flush <= n_flush;
            r_hold_v <= n_hold_v;
            r_out_v <= n_out_v;
            r_match <= n_match;
            r_idx <= n_idx;
            r_hits <= n_hits;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_err_code <= n_err_code;
        r_err_rank <= n_err_rank;
        r_ptr <= n_ptr;
        r_span_rank <= n_span_rank;
        r_want <= n_want;
        r_min <= n_min;
        r_gap <= n_gap;
        r_hs <= n_hs;
        r_hl <= n_hl;
        r_nres <= n_nres;
        r_hold <= n_hold;
        r_out <= n_out;
    end

`ifndef SYNTH
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("A result is still held while the block is idle.");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RECORD_SLOTS))
        else $error("Record store fill count exceeds its depth.");
    a_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= GW'(GROUP_SLOTS))
        else $error("Group count exceeds the table depth.");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt != rgr_pkg::ERR_NONE) |=> (r_halt == $past(r_halt)))
        else $error("Halt code changed after an error.");
`endif

endmodule
`default_nettype wire
